### sv/quad_to_triangle_indexer_top_assert.svh
// Assertion macros for the quad to triangle indexer.
`ifndef QUAD_TO_TRIANGLE_INDEXER_TOP_ASSERT_SVH
`define QUAD_TO_TRIANGLE_INDEXER_TOP_ASSERT_SVH

// same-cycle implication
`define Q2TI_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("q2ti assertion failed");

// next-cycle implication
`define Q2TI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("q2ti assertion failed");

`endif

### sv/q2ti_pkg.sv
// Package: types, constants and helpers of the quad to triangle indexer.
`default_nettype none
package q2ti_pkg;

   localparam int INDEX_BITS      = 16;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_BITS  = 4;
   localparam int STEP_BITS       = 3;
   localparam logic [STEP_BITS-1:0] LAST_STEP = 3'd5;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDING_CLOCKWISE = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GENERATE_INDICES  = 4'd1;

   typedef logic [INDEX_BITS-1:0] index_type;

   typedef struct packed {
      logic [15:0] vertex_index;
      logic        end_of_draw;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] tri_index;
      logic        quad_done;
   } rsp_payload_type;

   typedef struct packed {
      index_type a;
      index_type b;
      index_type c;
      index_type d;
      logic      clockwise;
   } quad_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic index_type to_index(input logic [15:0] value);
      logic [INDEX_BITS+15:0] ext;
      ext = {{INDEX_BITS{1'b0}}, value};
      return ext[INDEX_BITS-1:0];
   endfunction

   function automatic logic [15:0] to_out(input index_type value);
      logic [INDEX_BITS+15:0] ext;
      ext = {16'b0, value};
      return ext[15:0];
   endfunction

endpackage
`default_nettype wire

### sv/quad_to_triangle_indexer_top.sv
// Top level of the quad-list to triangle-list index converter.
// Usage:
//   Input: quad-list vertex indices are pushed with req_push while req_full is
//   low. Every fourth vertex completes a quad that enters a two-deep queue.
//   Output: six triangle-list indices per quad, oldest on rsp_payload while
//   rsp_empty is low, taken with rsp_pop; quad_done marks the sixth.
//   Config: csr_valid writes csr_data into register csr_index (0 winding,
//   1 generated mode); csr_ready is always high.
//   Path: with the back end idle, the first index of a quad is visible once the
//   quad has been written into the queue and then loaded into the back end.
//   Throughput: one result per cycle while rsp_pop is high, so the single
//   result port, not the front, sets the sustained vertex rate.
//   Reset: winding clockwise, generated mode off, no corners held, counter
//   cleared, queue and result port empty.
//   Stall: while rsp_pop is low the current result holds; the front keeps
//   taking vertices until the quad queue is full, then raises req_full.
`default_nettype none
module quad_to_triangle_indexer_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire q2ti_pkg::req_payload_type           req_payload,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output q2ti_pkg::rsp_payload_type                rsp_payload,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [q2ti_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic                                csr_data
);
   import q2ti_pkg::*;

   queue_status_type q_status;
   quad_type         push_data, pop_data;
   logic             q_push, q_pop;

   assign csr_ready = 1'b1;

   q2ti_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_payload (req_payload),
      .req_full    (req_full),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_data      (push_data)
   );

   q2ti_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   q2ti_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .q_data      (pop_data),
      .q_pop       (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

`include "quad_to_triangle_indexer_top_assert.svh"

   `Q2TI_ASSERT_NEXT(a_mid_quad_continues, clock, reset,
      !rsp_empty && rsp_pop && !rsp_payload.quad_done, !rsp_empty)
   `Q2TI_ASSERT_NEXT(a_queued_quad_served, clock, reset, !q_status.empty, !rsp_empty)
   `Q2TI_ASSERT_IMPLIES(a_no_push_when_full, clock, reset, q_status.full, !q_push)

endmodule
`default_nettype wire

### sv/q2ti_front.sv
// Front end: configuration, corner collection and vertex counter.
`default_nettype none
module q2ti_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_push,
   input  wire q2ti_pkg::req_payload_type          req_payload,
   output logic                                    req_full,
   input  wire logic                               csr_valid,
   input  wire logic [q2ti_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic                               csr_data,
   input  wire q2ti_pkg::queue_status_type         q_status,
   output logic                                    q_push,
   output q2ti_pkg::quad_type                      q_data
);
   import q2ti_pkg::*;

   logic      winding_ff, winding_in;
   logic      generate_ff, generate_in;
   logic [1:0] pos_ff, pos_in;
   index_type seq_ff, seq_in;
   index_type hold_ff [3];
   index_type vertex;
   logic      accept;

   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;
   assign vertex   = generate_ff ? seq_ff : to_index(req_payload.vertex_index);

   always_comb begin
      winding_in  = winding_ff;
      generate_in = generate_ff;
      if (csr_valid) begin
         if (csr_index == CSR_WINDING_CLOCKWISE) winding_in = csr_data;
         if (csr_index == CSR_GENERATE_INDICES)  generate_in = csr_data;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      seq_in = seq_ff;
      if (accept) begin
         if (generate_ff) seq_in = seq_ff + 1'b1;
         if (pos_ff == 2'd3) pos_in = 2'd0;
         else                pos_in = pos_ff + 2'd1;
         if (req_payload.end_of_draw) begin
            pos_in = 2'd0;
            seq_in = '0;
         end
      end
   end

   assign q_push         = accept && (pos_ff == 2'd3);
   assign q_data.a         = hold_ff[0];
   assign q_data.b         = hold_ff[1];
   assign q_data.c         = hold_ff[2];
   assign q_data.d         = vertex;
   assign q_data.clockwise = winding_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         winding_ff  <= 1'b1;
         generate_ff <= 1'b0;
         pos_ff      <= 2'd0;
         seq_ff      <= '0;
      end else begin
         winding_ff  <= winding_in;
         generate_ff <= generate_in;
         pos_ff      <= pos_in;
         seq_ff      <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         unique case (pos_ff)
            2'd0: hold_ff[0] <= vertex;
            2'd1: hold_ff[1] <= vertex;
            2'd2: hold_ff[2] <= vertex;
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

### sv/q2ti_queue.sv
// Short queue of complete quads between front and back end.
`default_nettype none
module q2ti_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire q2ti_pkg::quad_type          push_data,
   input  wire logic                        pop,
   output q2ti_pkg::quad_type               pop_data,
   output q2ti_pkg::queue_status_type       status
);
   import q2ti_pkg::*;

   localparam logic [QUEUE_PTR_BITS-1:0] PTR_LAST = QUEUE_PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_BITS-1:0] CNT_FULL = QUEUE_CNT_BITS'(QUEUE_DEPTH);

   quad_type                  mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                      do_push, do_pop;

   assign status.full  = (cnt_ff == CNT_FULL);
   assign status.empty = (cnt_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = mem[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop)      cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ff] <= push_data;
   end

endmodule
`default_nettype wire

### sv/q2ti_back.sv
// Back end: emits the six triangle indices of each quad, one per transaction.
`default_nettype none
module q2ti_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire q2ti_pkg::queue_status_type q_status,
   input  wire q2ti_pkg::quad_type      q_data,
   output logic                         q_pop,
   output logic                         rsp_empty,
   input  wire logic                    rsp_pop,
   output q2ti_pkg::rsp_payload_type    rsp_payload
);
   import q2ti_pkg::*;

   logic                 busy_ff, busy_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   quad_type             quad_ff;
   logic                 taken, last;
   index_type            sel;

   assign rsp_empty = !busy_ff;
   assign taken     = busy_ff && rsp_pop;
   assign last      = (step_ff == LAST_STEP);
   assign q_pop     = !q_status.empty && (!busy_ff || (taken && last));

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (taken) begin
         if (last) busy_in = 1'b0;
         else      step_in = step_ff + 1'b1;
      end
   end

   always_comb begin
      unique case (step_ff)
         3'd0:    sel = quad_ff.a;
         3'd1:    sel = quad_ff.clockwise ? quad_ff.b : quad_ff.d;
         3'd2:    sel = quad_ff.clockwise ? quad_ff.d : quad_ff.b;
         3'd3:    sel = quad_ff.b;
         3'd4:    sel = quad_ff.clockwise ? quad_ff.c : quad_ff.d;
         default: sel = quad_ff.clockwise ? quad_ff.d : quad_ff.c;
      endcase
   end

   assign rsp_payload.tri_index = to_out(sel);
   assign rsp_payload.quad_done = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) quad_ff <= q_data;
   end

endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the quad-list to triangle-list index converter.
`timescale 1ns / 1ps
module testbench;
   import q2ti_pkg::*;

   localparam int HALF_PERIOD = 4;
   localparam int RESET_CYCLES = 8;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD = 150;
   localparam int PHASE_ITEMS = 85;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_FIRST =
      CSR_INDEX_BITS'(CSR_GENERATE_INDICES + 1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_LAST = {CSR_INDEX_BITS{1'b1}};

   class tri_index_scoreboard;
      logic [15:0] corners[3];
      logic [1:0] corner_count;
      logic [15:0] next_generated;
      logic clockwise;
      logic generated;
      rsp_payload_type pending_indices[$];
      int mismatches;
      int vertices_seen;
      int quads_emitted;
      int indices_checked;

      function new();
         corners = '{16'h0, 16'h0, 16'h0};
         corner_count = 2'd0;
         next_generated = 16'h0;
         clockwise = 1'b1;
         generated = 1'b0;
         mismatches = 0;
         vertices_seen = 0;
         quads_emitted = 0;
         indices_checked = 0;
      endfunction

      function void apply_csr(logic [CSR_INDEX_BITS-1:0] idx, logic data);
         if (idx == CSR_WINDING_CLOCKWISE)
            clockwise = data;
         else if (idx == CSR_GENERATE_INDICES)
            generated = data;
      endfunction

      function void assemble_vertex(req_payload_type item);
         logic [15:0] v;
         logic [15:0] order[6];
         rsp_payload_type e;
         vertices_seen++;
         if (generated) begin
            v = next_generated;
            next_generated = next_generated + 16'd1;
         end else begin
            v = item.vertex_index;
         end
         if (corner_count != 2'd3) begin
            corners[corner_count] = v;
            corner_count = corner_count + 2'd1;
         end else begin
            if (clockwise)
               order = '{corners[0], corners[1], v, corners[1], corners[2], v};
            else
               order = '{corners[0], v, corners[1], corners[1], v, corners[2]};
            for (int i = 0; i < 6; i++) begin
               e.tri_index = order[i];
               e.quad_done = (i == 5);
               pending_indices.push_back(e);
            end
            quads_emitted++;
            corner_count = 2'd0;
         end
         if (item.end_of_draw) begin
            corner_count = 2'd0;
            next_generated = 16'h0;
         end
      endfunction

      function void match_index(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_indices.size() == 0) begin
            $error("unexpected transaction: tri_index %0d quad_done %0b",
                   got.tri_index, got.quad_done);
            mismatches++;
            return;
         end
         want = pending_indices.pop_front();
         indices_checked++;
         if (got.tri_index !== want.tri_index) begin
            $error("tri_index mismatch: expected %0d, actual %0d",
                   want.tri_index, got.tri_index);
            mismatches++;
         end
         if (got.quad_done !== want.quad_done) begin
            $error("quad_done mismatch: expected %0b, actual %0b",
                   want.quad_done, got.quad_done);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   req_payload_type req_payload = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic csr_data = 1'b0;

   tri_index_scoreboard sb;
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   int rx_hold_left = 0;
   int csr_writes = 0;

   quad_to_triangle_indexer_top i_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_payload(req_payload),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   initial begin
      #10ms;
      $display("quad_to_triangle_indexer_top regression: fail");
      $finish;
   end

   // result side: check accepted transactions, then choose next pop
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty)
            sb.match_index(rsp_payload);
         if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= rx_stall_pct);
         end
      end
   end

   function automatic logic [15:0] random_vertex();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // leaves req_push high unless an idle gap follows; caller sends again or drains
   task automatic send_vertex(input logic [15:0] idx, input logic last);
      req_payload_type item;
      item.vertex_index = idx;
      item.end_of_draw = last;
      req_payload <= item;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      sb.assemble_vertex(item);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (sb.pending_indices.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx, input logic data);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.apply_csr(idx, data);
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int idle_table[4];
      int stall_table[4];
      idle_table = '{0, 54, 0, 31};
      stall_table = '{0, 0, 54, 31};
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unmapped registers must not alias the real ones
      write_csr(CSR_UNMAPPED_FIRST, 1'b0);
      write_csr(CSR_UNMAPPED_FIRST + 1'b1, 1'b1);
      write_csr(CSR_UNMAPPED_LAST, 1'b0);

      // reset settings, field extremes
      send_vertex(16'h0000, 1'b0);
      send_vertex(16'hFFFF, 1'b0);
      send_vertex(16'hAAAA, 1'b0);
      send_vertex(16'h5555, 1'b0);
      wait_drained();
      write_csr(CSR_WINDING_CLOCKWISE, 1'b0);

      // end of draw on the fourth corner
      send_vertex(16'h5555, 1'b0);
      send_vertex(16'hAAAA, 1'b0);
      send_vertex(16'hFFFF, 1'b0);
      send_vertex(16'h0000, 1'b1);
      // end of draw on first, second and third corner
      send_vertex(16'h1234, 1'b1);
      send_vertex(16'h4321, 1'b0);
      send_vertex(16'h8765, 1'b1);
      send_vertex(16'h0F0F, 1'b0);
      send_vertex(16'hF0F0, 1'b0);
      send_vertex(16'h00FF, 1'b1);

      // registers change half way through a quad
      send_vertex(16'h8000, 1'b0);
      send_vertex(16'h0001, 1'b0);
      wait_drained();
      write_csr(CSR_WINDING_CLOCKWISE, 1'b1);
      write_csr(CSR_GENERATE_INDICES, 1'b1);
      send_vertex(16'hFFFF, 1'b0);
      send_vertex(16'hFFFF, 1'b0);
      send_vertex(16'h0000, 1'b0);
      send_vertex(16'h0000, 1'b0);
      send_vertex(16'h0000, 1'b0);
      send_vertex(16'h0000, 1'b1);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         tx_idle_pct = idle_table[p];
         rx_stall_pct = stall_table[p];
         write_csr(CSR_WINDING_CLOCKWISE, ~p[0]);
         write_csr(CSR_GENERATE_INDICES, p[1]);
         write_csr(CSR_INDEX_BITS'($urandom_range(CSR_UNMAPPED_FIRST, CSR_UNMAPPED_LAST)),
                   1'($urandom_range(0, 1)));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 0 && n == 10)
               rx_hold_left = LONG_HOLD;
            if (n == PHASE_ITEMS / 2) begin
               wait_drained();
               write_csr(CSR_WINDING_CLOCKWISE, 1'($urandom_range(0, 1)));
            end
            send_vertex(random_vertex(), $urandom_range(0, 11) == 0);
         end
         wait_drained();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d vertices sent, %0d quads, %0d triangle indices checked, %0d register writes",
               sb.vertices_seen, sb.quads_emitted, sb.indices_checked, csr_writes);
      $display("both windings, explicit and generated indices, end of draw on %s",
               "every corner, unmapped registers, idle/stall mixes and a long result stall");
      if (sb.mismatches == 0 && sb.pending_indices.size() == 0)
         $display("quad_to_triangle_indexer_top regression: pass");
      else
         $display("quad_to_triangle_indexer_top regression: fail");
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/q2ti_pkg.sv
sv/q2ti_front.sv
sv/q2ti_queue.sv
sv/q2ti_back.sv
sv/quad_to_triangle_indexer_top.sv
verif/testbench.sv
